FILE: src/assert_macros.svh
// Assertion macros for the box range query index RTL.
// Needs aclk and aresetn in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BRQI_ASSERT_IMM(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BRQI_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/brqi_pkg.sv
// Package for the box range query index: request modes, status codes,
// result record and controller states. No dependencies.
package brqi_pkg;

    localparam int NUM_AXES = 3;
    localparam int ID_OUT_W = 6;

    typedef enum logic [1:0] {
        MODE_CLEAR = 2'd0,
        MODE_ADD   = 2'd1,
        MODE_BUILD = 2'd2,
        MODE_QUERY = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_FULL      = 3'd1,
        ST_BOUNDS    = 3'd2,
        ST_NOT_BUILT = 3'd3,
        ST_BUILT     = 3'd4
    } status_t;

    typedef struct packed {
        status_t              status;
        logic [ID_OUT_W-1:0]  point_id;
        logic                 hit;
        logic                 last;
    } result_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RESP,
        B_RD_I,
        B_LD_I,
        B_SCAN,
        B_WR,
        Q_SA,
        Q_SB,
        Q_SC,
        Q_PICK,
        Q_RA,
        Q_RB,
        Q_RC,
        Q_RD,
        Q_FIN
    } state_t;

endpackage

FILE: src/brqi_ram.sv
// Simple dual-port synchronous RAM, one write and one read port.
// Read data is registered: it appears in the cycle after the read address. No dependencies.
module brqi_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        rdata <= mem[raddr];
    end

endmodule

FILE: src/brqi_out_reg.sv
// Output register of the result channel: holds one result until taken.
// Depends on brqi_pkg for the result record.
module brqi_out_reg (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  brqi_pkg::result_t push_res,
    output logic              free,
    output logic              m_valid,
    input  logic              m_ready,
    output brqi_pkg::result_t m_res
);
    import brqi_pkg::*;

    logic    valid_reg, valid_next;
    result_t res_reg;

    assign free    = !valid_reg || m_ready;
    assign m_valid = valid_reg;
    assign m_res   = res_reg;

    always_comb begin
        valid_next = valid_reg;
        if (push) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            res_reg <= push_res;
        end
    end

endmodule

FILE: src/box_range_query_index.sv
// Top level of the box range query index: controller, coordinate and
// sorted id memories. Depends on brqi_pkg, brqi_ram, brqi_out_reg, assert_macros.svh.
//
//  Channel  Direction  Handshake          Carries
//  s_       in         s_valid/s_ready    mode, point, box bounds
//  m_       out        m_valid/m_ready    status, point_id, hit, last
//
// Clear and add each answer with one status result; build ranks every stored
// point with a rank count that reads every coordinate once per point.
// A query runs its lower search and then its upper search on all three axes in
// step, picks the axis with the fewest candidates, then reads and tests each
// entry of the chosen range and finishes with the last result.
// Reset is synchronous and active low; it empties the index but leaves memories as they are.
// A request is taken only in the idle state; a stalled result channel holds the controller.
`include "assert_macros.svh"

module box_range_query_index #(
    parameter int MAX_POINTS = 64,
    parameter int COORD_BITS = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  brqi_pkg::mode_t       s_mode,
    input  logic signed [31:0]    s_point_x,
    input  logic signed [31:0]    s_point_y,
    input  logic signed [31:0]    s_point_z,
    input  logic signed [31:0]    s_box_low_x,
    input  logic signed [31:0]    s_box_low_y,
    input  logic signed [31:0]    s_box_low_z,
    input  logic signed [31:0]    s_box_high_x,
    input  logic signed [31:0]    s_box_high_y,
    input  logic signed [31:0]    s_box_high_z,
    output logic                  m_valid,
    input  logic                  m_ready,
    output brqi_pkg::status_t     m_status,
    output logic [5:0]            m_point_id,
    output logic                  m_hit,
    output logic                  m_last
);
    import brqi_pkg::*;

    localparam int IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CNT_W = $clog2(MAX_POINTS + 1);

    typedef logic signed [COORD_BITS-1:0] coord_t;

    // A coordinate is the input sign-extended and then cut to COORD_BITS, which
    // keeps the low bits for narrow coordinates and extends for wide ones.
    function automatic coord_t to_coord(input logic signed [31:0] v);
        logic signed [63:0] e;
        e = 64'(v);
        return e[COORD_BITS-1:0];
    endfunction

    // Control state.
    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              built_reg, built_next;
    status_t           res_status_reg, res_status_next;

    // Build: rank of point i on each axis, counted over all j.
    logic [CNT_W-1:0]  i_reg, i_next;
    logic [CNT_W-1:0]  j_reg, j_next;
    logic [CNT_W-1:0]  jd_reg, jd_next;
    logic              dv_reg, dv_next;
    coord_t            ci_reg [NUM_AXES];
    coord_t            ci_next [NUM_AXES];
    logic [IDX_W-1:0]  rank_reg [NUM_AXES];
    logic [IDX_W-1:0]  rank_next [NUM_AXES];

    // Query: keys, binary search bounds and the chosen range.
    coord_t            lo_key_reg [NUM_AXES];
    coord_t            lo_key_next [NUM_AXES];
    coord_t            hi_key_reg [NUM_AXES];
    coord_t            hi_key_next [NUM_AXES];
    logic [CNT_W-1:0]  lo_reg [NUM_AXES];
    logic [CNT_W-1:0]  lo_next [NUM_AXES];
    logic [CNT_W-1:0]  hi_reg [NUM_AXES];
    logic [CNT_W-1:0]  hi_next [NUM_AXES];
    logic [CNT_W-1:0]  start_reg [NUM_AXES];
    logic [CNT_W-1:0]  start_next [NUM_AXES];
    logic [CNT_W-1:0]  end_reg [NUM_AXES];
    logic [CNT_W-1:0]  end_next [NUM_AXES];
    logic [CNT_W-1:0]  mid [NUM_AXES];
    logic              phase_reg, phase_next;
    logic [1:0]        best_reg, best_next;
    logic [CNT_W-1:0]  p_reg, p_next;
    logic [CNT_W-1:0]  end_sel_reg, end_sel_next;
    logic [IDX_W-1:0]  id_reg, id_next;
    logic              pend_valid_reg, pend_valid_next;
    logic [IDX_W-1:0]  pend_id_reg, pend_id_next;

    // Memory ports.
    logic              coord_we;
    coord_t            coord_wdata [NUM_AXES];
    logic [IDX_W-1:0]  coord_raddr [NUM_AXES];
    coord_t            coord_rdata [NUM_AXES];
    logic              sorted_we;
    logic [IDX_W-1:0]  sorted_raddr [NUM_AXES];
    logic [IDX_W-1:0]  sorted_rdata [NUM_AXES];

    // Output register interface.
    logic              out_push;
    logic              out_free;
    result_t           out_res;
    result_t           m_res;

    logic              accept;

    assign accept  = s_valid && s_ready;
    assign s_ready = (state_reg == S_IDLE);

    assign coord_wdata[0] = to_coord(s_point_x);
    assign coord_wdata[1] = to_coord(s_point_y);
    assign coord_wdata[2] = to_coord(s_point_z);

    for (genvar a = 0; a < NUM_AXES; a++) begin : g_axis
        assign mid[a] = lo_reg[a] + ((hi_reg[a] - lo_reg[a]) >> 1);

        brqi_ram #(
            .WIDTH  (COORD_BITS),
            .DEPTH  (MAX_POINTS),
            .ADDR_W (IDX_W)
        ) u_coord_ram (
            .aclk  (aclk),
            .we    (coord_we),
            .waddr (count_reg[IDX_W-1:0]),
            .wdata (coord_wdata[a]),
            .raddr (coord_raddr[a]),
            .rdata (coord_rdata[a])
        );

        brqi_ram #(
            .WIDTH  (IDX_W),
            .DEPTH  (MAX_POINTS),
            .ADDR_W (IDX_W)
        ) u_sorted_ram (
            .aclk  (aclk),
            .we    (sorted_we),
            .waddr (rank_reg[a]),
            .wdata (i_reg[IDX_W-1:0]),
            .raddr (sorted_raddr[a]),
            .rdata (sorted_rdata[a])
        );
    end

    // Main controller. Writes to the coordinate memories happen only on an add
    // in the idle state and to the sorted memories only during build, so no
    // read ever overlaps a write to the same entry.
    always_comb begin
        logic              all_done;
        logic              below_key;
        logic              in_box;
        logic [CNT_W-1:0]  size;
        logic [CNT_W:0]    bsize;
        coord_t            v;
        coord_t            bl [NUM_AXES];
        coord_t            bh [NUM_AXES];

        state_next      = state_reg;
        count_next      = count_reg;
        built_next      = built_reg;
        res_status_next = res_status_reg;
        i_next          = i_reg;
        j_next          = j_reg;
        jd_next         = jd_reg;
        dv_next         = dv_reg;
        ci_next         = ci_reg;
        rank_next       = rank_reg;
        lo_key_next     = lo_key_reg;
        hi_key_next     = hi_key_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        start_next      = start_reg;
        end_next        = end_reg;
        phase_next      = phase_reg;
        best_next       = best_reg;
        p_next          = p_reg;
        end_sel_next    = end_sel_reg;
        id_next         = id_reg;
        pend_valid_next = pend_valid_reg;
        pend_id_next    = pend_id_reg;

        coord_we  = 1'b0;
        sorted_we = 1'b0;
        for (int a = 0; a < NUM_AXES; a++) begin
            coord_raddr[a]  = '0;
            sorted_raddr[a] = '0;
        end
        out_push = 1'b0;
        out_res  = '{status: ST_OK, point_id: '0, hit: 1'b0, last: 1'b1};

        all_done  = 1'b1;
        below_key = 1'b0;
        in_box    = 1'b1;
        size      = '0;
        bsize     = '0;
        v         = '0;
        bl[0] = to_coord(s_box_low_x);
        bl[1] = to_coord(s_box_low_y);
        bl[2] = to_coord(s_box_low_z);
        bh[0] = to_coord(s_box_high_x);
        bh[1] = to_coord(s_box_high_y);
        bh[2] = to_coord(s_box_high_z);

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    res_status_next = ST_OK;
                    state_next      = S_RESP;
                    unique case (s_mode)
                        MODE_CLEAR: begin
                            count_next = '0;
                            built_next = 1'b0;
                        end
                        MODE_ADD: begin
                            if (built_reg) begin
                                res_status_next = ST_BUILT;
                            end else if (count_reg == CNT_W'(MAX_POINTS)) begin
                                res_status_next = ST_FULL;
                            end else begin
                                coord_we   = 1'b1;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        MODE_BUILD: begin
                            built_next = 1'b1;
                            i_next     = '0;
                            if (count_reg != '0) begin
                                state_next = B_RD_I;
                            end
                        end
                        MODE_QUERY: begin
                            lo_key_next = bl;
                            hi_key_next = bh;
                            if (!built_reg) begin
                                res_status_next = ST_NOT_BUILT;
                            end else if (bl[0] > bh[0] || bl[1] > bh[1] || bl[2] > bh[2]) begin
                                res_status_next = ST_BOUNDS;
                            end else begin
                                for (int a = 0; a < NUM_AXES; a++) begin
                                    lo_next[a] = '0;
                                    hi_next[a] = count_reg;
                                end
                                phase_next = 1'b0;
                                state_next = Q_SA;
                            end
                        end
                        default: ;
                    endcase
                end
            end

            S_RESP: begin
                out_res.status = res_status_reg;
                if (out_free) begin
                    out_push   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            B_RD_I: begin
                for (int a = 0; a < NUM_AXES; a++) begin
                    coord_raddr[a] = i_reg[IDX_W-1:0];
                end
                state_next = B_LD_I;
            end

            B_LD_I: begin
                ci_next = coord_rdata;
                for (int a = 0; a < NUM_AXES; a++) begin
                    rank_next[a] = '0;
                end
                j_next     = '0;
                dv_next    = 1'b0;
                state_next = B_SCAN;
            end

            B_SCAN: begin
                // Reads run one entry ahead of the comparison.
                if (j_reg < count_reg) begin
                    for (int a = 0; a < NUM_AXES; a++) begin
                        coord_raddr[a] = j_reg[IDX_W-1:0];
                    end
                    j_next  = j_reg + 1'b1;
                    jd_next = j_reg;
                    dv_next = 1'b1;
                end else begin
                    dv_next = 1'b0;
                end
                if (dv_reg) begin
                    for (int a = 0; a < NUM_AXES; a++) begin
                        if (coord_rdata[a] < ci_reg[a] ||
                            (coord_rdata[a] == ci_reg[a] && jd_reg < i_reg)) begin
                            rank_next[a] = rank_reg[a] + 1'b1;
                        end
                    end
                end
                if (j_reg == count_reg && !dv_reg) begin
                    state_next = B_WR;
                end
            end

            B_WR: begin
                sorted_we = 1'b1;
                if (i_reg + 1'b1 == count_reg) begin
                    state_next = S_RESP;
                end else begin
                    i_next     = i_reg + 1'b1;
                    state_next = B_RD_I;
                end
            end

            Q_SA: begin
                for (int a = 0; a < NUM_AXES; a++) begin
                    if (lo_reg[a] < hi_reg[a]) begin
                        all_done = 1'b0;
                    end
                    sorted_raddr[a] = mid[a][IDX_W-1:0];
                end
                if (all_done) begin
                    if (!phase_reg) begin
                        start_next = lo_reg;
                        for (int a = 0; a < NUM_AXES; a++) begin
                            lo_next[a] = '0;
                            hi_next[a] = count_reg;
                        end
                        phase_next = 1'b1;
                    end else begin
                        end_next   = lo_reg;
                        state_next = Q_PICK;
                    end
                end else begin
                    state_next = Q_SB;
                end
            end

            Q_SB: begin
                for (int a = 0; a < NUM_AXES; a++) begin
                    coord_raddr[a] = sorted_rdata[a];
                end
                state_next = Q_SC;
            end

            Q_SC: begin
                for (int a = 0; a < NUM_AXES; a++) begin
                    if (lo_reg[a] < hi_reg[a]) begin
                        v         = coord_rdata[a];
                        below_key = phase_reg ? (v <= hi_key_reg[a]) : (v < lo_key_reg[a]);
                        if (below_key) begin
                            lo_next[a] = mid[a] + 1'b1;
                        end else begin
                            hi_next[a] = mid[a];
                        end
                    end
                end
                state_next = Q_SA;
            end

            Q_PICK: begin
                // Fewest candidates wins; the earlier axis keeps a tie.
                bsize = {1'b0, count_reg} + 1'b1;
                for (int a = 0; a < NUM_AXES; a++) begin
                    size = (end_reg[a] > start_reg[a]) ? end_reg[a] - start_reg[a] : '0;
                    if ({1'b0, size} < bsize) begin
                        bsize        = {1'b0, size};
                        best_next    = 2'(a);
                        p_next       = start_reg[a];
                        end_sel_next = end_reg[a];
                    end
                end
                pend_valid_next = 1'b0;
                state_next      = Q_RA;
            end

            Q_RA: begin
                for (int a = 0; a < NUM_AXES; a++) begin
                    sorted_raddr[a] = p_reg[IDX_W-1:0];
                end
                if (p_reg < end_sel_reg) begin
                    state_next = Q_RB;
                end else begin
                    state_next = Q_FIN;
                end
            end

            Q_RB: begin
                id_next = sorted_rdata[best_reg];
                for (int a = 0; a < NUM_AXES; a++) begin
                    coord_raddr[a] = sorted_rdata[best_reg];
                end
                state_next = Q_RC;
            end

            Q_RC: begin
                for (int a = 0; a < NUM_AXES; a++) begin
                    if (coord_rdata[a] < lo_key_reg[a] || coord_rdata[a] > hi_key_reg[a]) begin
                        in_box = 1'b0;
                    end
                end
                // A hit is held back one step so that the final one can carry last.
                if (in_box && pend_valid_reg) begin
                    state_next = Q_RD;
                end else begin
                    if (in_box) begin
                        pend_valid_next = 1'b1;
                        pend_id_next    = id_reg;
                    end
                    p_next     = p_reg + 1'b1;
                    state_next = Q_RA;
                end
            end

            Q_RD: begin
                out_res = '{status: ST_OK, point_id: ID_OUT_W'(pend_id_reg),
                            hit: 1'b1, last: 1'b0};
                if (out_free) begin
                    out_push     = 1'b1;
                    pend_id_next = id_reg;
                    p_next       = p_reg + 1'b1;
                    state_next   = Q_RA;
                end
            end

            Q_FIN: begin
                if (pend_valid_reg) begin
                    out_res = '{status: ST_OK, point_id: ID_OUT_W'(pend_id_reg),
                                hit: 1'b1, last: 1'b1};
                end
                if (out_free) begin
                    out_push   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            built_reg      <= 1'b0;
            dv_reg         <= 1'b0;
            pend_valid_reg <= 1'b0;
        end else begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            built_reg      <= built_next;
            dv_reg         <= dv_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        res_status_reg <= res_status_next;
        i_reg          <= i_next;
        j_reg          <= j_next;
        jd_reg         <= jd_next;
        ci_reg         <= ci_next;
        rank_reg       <= rank_next;
        lo_key_reg     <= lo_key_next;
        hi_key_reg     <= hi_key_next;
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        start_reg      <= start_next;
        end_reg        <= end_next;
        phase_reg      <= phase_next;
        best_reg       <= best_next;
        p_reg          <= p_next;
        end_sel_reg    <= end_sel_next;
        id_reg         <= id_next;
        pend_id_reg    <= pend_id_next;
    end

    brqi_out_reg u_out_reg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (out_push),
        .push_res (out_res),
        .free     (out_free),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_res    (m_res)
    );

    assign m_status   = m_res.status;
    assign m_point_id = m_res.point_id;
    assign m_hit      = m_res.hit;
    assign m_last     = m_res.last;

    // The controller never overwrites a result that is still waiting.
    `BRQI_ASSERT_IMM(a_push_free, out_push, out_free, "result pushed into a full output register")
    // The fill count never passes the capacity.
    `BRQI_ASSERT_IMM(a_count_range, 1'b1, count_reg <= CNT_W'(MAX_POINTS), "stored count too large")
    // A hit result always carries the ok status.
    `BRQI_ASSERT_IMM(a_hit_ok, out_push && out_res.hit, out_res.status == ST_OK, "hit with error status")
    // The final result of a request returns the controller to idle.
    `BRQI_ASSERT_NXT(a_last_idle, out_push && out_res.last, state_reg == S_IDLE, "no idle after last result")

endmodule

FILE: tb/tb.sv
// Testbench for box_range_query_index: drives clear, add, build and query requests,
// predicts every result with its own point index model and checks them in order.
// Depends on brqi_pkg and the box_range_query_index RTL.
`timescale 1ns / 1ps

module tb;
    import brqi_pkg::*;

    localparam int CAPACITY = 64;
    localparam int WATCHDOG_LIMIT = 60000;

    // One request as the driver presents it.
    typedef struct {
        mode_t       mode;
        logic [31:0] pt [3];
        logic [31:0] lo [3];
        logic [31:0] hi [3];
    } request_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    mode_t s_mode = MODE_CLEAR;
    logic signed [31:0] s_point_x = '0, s_point_y = '0, s_point_z = '0;
    logic signed [31:0] s_box_low_x = '0, s_box_low_y = '0, s_box_low_z = '0;
    logic signed [31:0] s_box_high_x = '0, s_box_high_y = '0, s_box_high_z = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    status_t m_status;
    logic [5:0] m_point_id;
    logic m_hit;
    logic m_last;

    box_range_query_index dut (.*);

    always #6 aclk = ~aclk;

    // Predictor state: the stored points and the three sorted id lists.
    logic signed [31:0] stored_coord [3][CAPACITY];
    int                 axis_order [3][CAPACITY];
    int                 point_total;
    bit                 index_ready;

    request_t pending_requests [$];
    result_t  expected_results [$];
    int errors = 0;
    int requests_sent = 0;
    int results_seen = 0;
    int hits_seen = 0;
    bit stimulus_done = 0;
    bit hold_off_request = 0;

    function automatic void queue_request(request_t q);
        pending_requests = {pending_requests, q};
    endfunction

    function automatic void push_result(status_t st, logic [5:0] id, bit h, bit l);
        result_t r;
        r.status = st;
        r.point_id = id;
        r.hit = h;
        r.last = l;
        expected_results = {expected_results, r};
    endfunction

    // Stable insertion sort per axis: equal coordinates keep ascending id order.
    function automatic void sort_all_axes();
        int j;
        for (int a = 0; a < 3; a++) begin
            for (int i = 0; i < point_total; i++) begin
                j = i;
                while (j > 0 && stored_coord[a][axis_order[a][j-1]] > stored_coord[a][i]) begin
                    axis_order[a][j] = axis_order[a][j-1];
                    j--;
                end
                axis_order[a][j] = i;
            end
        end
    endfunction

    // First sorted position at or above the key, or strictly above it when upper is set.
    function automatic int bound_search(int a, logic signed [31:0] key, bit upper);
        int lo_pos, hi_pos, mid;
        logic signed [31:0] v;
        lo_pos = 0;
        hi_pos = point_total;
        while (lo_pos < hi_pos) begin
            mid = lo_pos + (hi_pos - lo_pos) / 2;
            v = stored_coord[a][axis_order[a][mid]];
            if (upper ? (v <= key) : (v < key)) lo_pos = mid + 1;
            else hi_pos = mid;
        end
        return lo_pos;
    endfunction

    function automatic void predict_request(request_t q);
        int best_axis, best_start, best_end, best_size, s, e, sz, id;
        int n_hits;
        bit in_box;
        case (q.mode)
            MODE_CLEAR: begin
                point_total = 0;
                index_ready = 0;
                push_result(ST_OK, 0, 0, 1);
            end
            MODE_ADD: begin
                if (index_ready) push_result(ST_BUILT, 0, 0, 1);
                else if (point_total >= CAPACITY) push_result(ST_FULL, 0, 0, 1);
                else begin
                    for (int a = 0; a < 3; a++) stored_coord[a][point_total] = q.pt[a];
                    point_total++;
                    push_result(ST_OK, 0, 0, 1);
                end
            end
            MODE_BUILD: begin
                sort_all_axes();
                index_ready = 1;
                push_result(ST_OK, 0, 0, 1);
            end
            default: begin
                if (!index_ready) begin
                    push_result(ST_NOT_BUILT, 0, 0, 1);
                    return;
                end
                for (int a = 0; a < 3; a++)
                    if ($signed(q.lo[a]) > $signed(q.hi[a])) begin
                        push_result(ST_BOUNDS, 0, 0, 1);
                        return;
                    end
                best_axis = 0;
                best_start = 0;
                best_end = 0;
                best_size = point_total + 1;
                for (int a = 0; a < 3; a++) begin
                    s = bound_search(a, q.lo[a], 0);
                    e = bound_search(a, q.hi[a], 1);
                    sz = (e > s) ? e - s : 0;
                    if (sz < best_size) begin
                        best_size = sz;
                        best_axis = a;
                        best_start = s;
                        best_end = e;
                    end
                end
                n_hits = 0;
                for (int p = best_start; p < best_end; p++) begin
                    id = axis_order[best_axis][p];
                    in_box = 1;
                    for (int a = 0; a < 3; a++)
                        if (stored_coord[a][id] < $signed(q.lo[a]) ||
                            stored_coord[a][id] > $signed(q.hi[a])) in_box = 0;
                    if (in_box) begin
                        push_result(ST_OK, id[5:0], 1, 0);
                        hits_seen++;
                        n_hits++;
                    end
                end
                if (n_hits > 0)
                    expected_results[$].last = 1;
                else
                    push_result(ST_OK, 0, 0, 1);
            end
        endcase
    endfunction

    // Coordinates are mostly drawn from a small grid so that boxes catch points and ties occur.
    function automatic logic [31:0] pick_coord();
        case ($urandom_range(0, 9))
            0: return $urandom();
            1: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
            default: return 32'($signed($urandom_range(0, 40)) - 20) <<< 8;
        endcase
    endfunction

    function automatic request_t make_request(mode_t m);
        request_t q;
        logic [31:0] t;
        q.mode = m;
        for (int a = 0; a < 3; a++) begin
            q.pt[a] = pick_coord();
            q.lo[a] = pick_coord();
            q.hi[a] = pick_coord();
            // Most boxes are well formed; a few keep inverted bounds.
            if ($signed(q.lo[a]) > $signed(q.hi[a]) && $urandom_range(0, 19) != 0) begin
                t = q.lo[a];
                q.lo[a] = q.hi[a];
                q.hi[a] = t;
            end
        end
        return q;
    endfunction

    function automatic request_t box_request(logic [31:0] lo_v, logic [31:0] hi_v);
        request_t q;
        q = make_request(MODE_QUERY);
        for (int a = 0; a < 3; a++) begin
            q.lo[a] = lo_v;
            q.hi[a] = hi_v;
        end
        return q;
    endfunction

    // Fill the request queue: a directed opening, then well-formed add/build/query
    // sessions with occasional stray requests.
    initial begin
        request_t q;
        int n_adds;
        q = make_request(MODE_QUERY);
        queue_request(q);                                     // query before any build
        q = make_request(MODE_ADD);
        q.pt = '{32'h80000000, 32'h7fffffff, 32'h0};
        queue_request(q);
        q.pt = '{32'h7fffffff, 32'h80000000, 32'hffffffff};
        queue_request(q);
        q.pt = '{32'h7fffffff, 32'h80000000, 32'hffffffff};   // duplicate point
        queue_request(q);
        queue_request(make_request(MODE_QUERY));              // still not built
        queue_request(make_request(MODE_BUILD));
        queue_request(make_request(MODE_ADD));                // add after build
        queue_request(box_request(32'h80000000, 32'h7fffffff));
        q = box_request(32'h0, 32'h0);
        q.lo[1] = 32'h1;                                      // lower above upper on y
        queue_request(q);
        queue_request(box_request(32'h100, 32'h200));         // empty query
        queue_request(make_request(MODE_BUILD));              // rebuild
        queue_request(make_request(MODE_CLEAR));
        queue_request(make_request(MODE_BUILD));              // build with nothing stored
        queue_request(box_request(32'h80000000, 32'h7fffffff));
        queue_request(make_request(MODE_CLEAR));
        // Fill to capacity and beyond, keeping y at zero and z small so queries return many.
        for (int i = 0; i < CAPACITY + 2; i++) begin
            q = make_request(MODE_ADD);
            q.pt = '{32'(i) << 8, 32'h0, 32'(i % 3)};
            queue_request(q);
        end
        queue_request(make_request(MODE_BUILD));
        queue_request(box_request(32'h80000000, 32'h7fffffff));
        queue_request(make_request(MODE_QUERY));
        while (pending_requests.size() < 260) begin
            queue_request(make_request(MODE_CLEAR));
            n_adds = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 10);
            for (int i = 0; i < n_adds; i++) queue_request(make_request(MODE_ADD));
            if ($urandom_range(0, 5) != 0) queue_request(make_request(MODE_BUILD));
            repeat ($urandom_range(2, 8))
                queue_request(make_request(mode_t'($urandom_range(0, 7) == 0 ?
                    $urandom_range(0, 2) : 3)));
        end
        stimulus_done = 1;
    end

    function automatic int gap_length();
        if ($urandom_range(0, 2) != 0) return 0;
        return ($urandom_range(0, 15) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
    endfunction

    // Acceptance is seen at the rising edge, where the request is also predicted.
    bit in_taken = 1'b0;
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            predict_request(pending_requests.pop_front());
            requests_sent++;
            in_taken <= 1'b1;
        end else begin
            in_taken <= 1'b0;
        end
    end

    // Request driver: changes inputs on the falling edge only.
    int send_gap = 0;
    always @(negedge aclk) begin
        if (aresetn) begin
            if (in_taken) begin
                send_gap = gap_length();
            end
            if (!s_valid || in_taken) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_valid <= 1'b0;
                end else if (pending_requests.size() > 0) begin
                    s_valid <= 1'b1;
                    s_mode <= pending_requests[0].mode;
                    s_point_x <= pending_requests[0].pt[0];
                    s_point_y <= pending_requests[0].pt[1];
                    s_point_z <= pending_requests[0].pt[2];
                    s_box_low_x <= pending_requests[0].lo[0];
                    s_box_low_y <= pending_requests[0].lo[1];
                    s_box_low_z <= pending_requests[0].lo[2];
                    s_box_high_x <= pending_requests[0].hi[0];
                    s_box_high_y <= pending_requests[0].hi[1];
                    s_box_high_z <= pending_requests[0].hi[2];
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Result-side readiness: random stalls, plus one long hold-off early in the run
    // while requests keep arriving, so that the block backs up into its input.
    int stall_left = 0;
    int hold_left = 0;
    bit hold_done = 0;
    always @(negedge aclk) begin
        if (aresetn) begin
            if (!hold_done && requests_sent >= 8) begin
                hold_done <= 1;
                hold_left <= 300;
                m_ready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                m_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left <= stall_left - 1;
                m_ready <= 1'b0;
            end else begin
                stall_left <= gap_length();
                m_ready <= 1'b1;
            end
        end
    end

    // Result monitor: the prediction is made at the accepting edge, well before
    // the first result of that request can be sampled.
    result_t exp_r;
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result status=%0d id=%0d hit=%0b last=%0b",
                         $time, m_status, m_point_id, m_hit, m_last);
                errors++;
            end else begin
                exp_r = expected_results.pop_front();
                if (m_status !== exp_r.status) begin
                    $display("%0t: status expected %0d actual %0d", $time, exp_r.status, m_status);
                    errors++;
                end
                if (m_point_id !== exp_r.point_id) begin
                    $display("%0t: point_id expected %0d actual %0d",
                             $time, exp_r.point_id, m_point_id);
                    errors++;
                end
                if (m_hit !== exp_r.hit) begin
                    $display("%0t: hit expected %0b actual %0b", $time, exp_r.hit, m_hit);
                    errors++;
                end
                if (m_last !== exp_r.last) begin
                    $display("%0t: last expected %0b actual %0b", $time, exp_r.last, m_last);
                    errors++;
                end
            end
        end
    end

    // Watchdog: counts cycles in which neither channel moves a request or result.
    int idle_cycles = 0;
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired, %0d results outstanding",
                     $time, expected_results.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        wait (stimulus_done && pending_requests.size() == 0 && !s_valid);
        wait (expected_results.size() == 0);
        repeat (100) @(posedge aclk);
        $display("Covered %0d requests, %0d results of which %0d hits.",
                 requests_sent, results_seen, hits_seen);
        if (errors == 0 && expected_results.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
